// File: hw/rtl/nfwa_pkg.sv
// ----------------------------------------------------------------------------
// nfwa_pkg
// Shared sizes, register codes, state encoding and interface structs for the
// frame window averager.
// ----------------------------------------------------------------------------
package nfwa_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int MAX_DIMS    = 64;

    localparam int DIM_W       = $clog2(MAX_DIMS);
    localparam int SLOT_W      = $clog2(MAX_WINDOW);
    localparam int CNT_W       = 7;
    localparam int HIST_ADDR_W = SLOT_W + DIM_W;
    localparam int HIST_DEPTH  = MAX_WINDOW * MAX_DIMS;
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 22;
    localparam int DIV_CNT_W   = $clog2(SUM_W + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CNT_W-1:0] VS_RESET  = 7'd40;
    localparam logic [CNT_W-1:0] WIN_RESET = 7'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VECTOR_SIZE   = 2'd0,
        CFG_WINDOW_FRAMES = 2'd1,
        CFG_ZERO_PAD      = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                       rd_en;
        logic                       wr_en;
        logic                       clear;
        logic [HIST_ADDR_W-1:0]     hist_addr;
        logic [DIM_W-1:0]           dim;
        logic signed [SAMPLE_W-1:0] wr_sample;
        logic signed [SUM_W-1:0]    wr_sum;
    } store_req_t;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [CNT_W-1:0]        divisor;
    } div_req_t;

endpackage

// File: hw/rtl/n_frame_window_averager.sv
// ----------------------------------------------------------------------------
// n_frame_window_averager
// Sliding window moving average over feature vectors, one element per
// transfer, with history and running sums held in on-chip memories.
// An element that does not emit gets a memory read, then the update; an
// emitting one also runs the serial divider (ST_DIV), then loads the output
// register (ST_OUT) once the output is free; input is taken only in ST_IDLE.
// The serial divider and the read-modify-write of the memories set the rate.
// Reset clears all counters and sum valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module n_frame_window_averager
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [nfwa_pkg::SAMPLE_W-1:0]        s_tdata,   // [15:0] sample
    input  logic                                 s_tuser,   // [0] end_of_utterance
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [nfwa_pkg::SAMPLE_W-1:0]        m_tdata,   // [15:0] average
    output logic [nfwa_pkg::DIM_W-1:0]           m_tuser,   // [5:0] dimension
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nfwa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [nfwa_pkg::CFG_DATA_W-1:0]      cfg_data
);

    nfwa_pkg::state_t state_reg;
    nfwa_pkg::state_t state_next;

    logic [nfwa_pkg::CNT_W-1:0]       vs_reg;
    logic [nfwa_pkg::CNT_W-1:0]       win_reg;
    logic                             zero_pad_reg;
    logic [nfwa_pkg::CNT_W-1:0]       frames_held_reg;
    logic [nfwa_pkg::SLOT_W-1:0]      oldest_slot_reg;
    logic [nfwa_pkg::DIM_W-1:0]       element_index_reg;
    logic [nfwa_pkg::CNT_W-1:0]       frames_in_chunk_reg;
    logic signed [nfwa_pkg::SAMPLE_W-1:0] sample_reg;
    logic                             eou_reg;
    logic                             m_tvalid_reg;
    logic [nfwa_pkg::SAMPLE_W-1:0]    m_tdata_reg;
    logic [nfwa_pkg::DIM_W-1:0]       m_tuser_reg;
    logic                             m_tlast_reg;

    logic [nfwa_pkg::CNT_W-1:0]       vs_eff;
    logic [nfwa_pkg::CNT_W-1:0]       win_eff;
    logic                             full;
    logic [nfwa_pkg::SLOT_W-1:0]      slot;
    logic                             frame_end;
    logic [nfwa_pkg::CNT_W-1:0]       fic_inc;
    logic [nfwa_pkg::CNT_W-1:0]       held_inc;
    logic [nfwa_pkg::CNT_W-1:0]       held;
    logic [nfwa_pkg::CNT_W-1:0]       divisor;
    logic                             emit;
    logic                             out_free;
    logic                             finish;
    logic                             out_load;
    logic                             cfg_write;
    logic                             cfg_clear;
    logic                             eou_clear;

    logic signed [nfwa_pkg::SAMPLE_W-1:0] hist_q;
    logic signed [nfwa_pkg::SUM_W-1:0]    sum_q;
    logic signed [nfwa_pkg::SUM_W-1:0]    new_sum;
    nfwa_pkg::store_req_t             store_req;
    nfwa_pkg::div_req_t               div_req;
    logic                             div_done;
    logic [nfwa_pkg::SAMPLE_W-1:0]    div_quotient;

    assign vs_eff  = (vs_reg == '0) ? nfwa_pkg::CNT_W'(1) :
                     (vs_reg > nfwa_pkg::CNT_W'(nfwa_pkg::MAX_DIMS)) ?
                     nfwa_pkg::CNT_W'(nfwa_pkg::MAX_DIMS) : vs_reg;
    assign win_eff = (win_reg == '0) ? nfwa_pkg::CNT_W'(1) :
                     (win_reg > nfwa_pkg::CNT_W'(nfwa_pkg::MAX_WINDOW)) ?
                     nfwa_pkg::CNT_W'(nfwa_pkg::MAX_WINDOW) : win_reg;

    assign full      = (frames_held_reg >= win_eff);
    assign slot      = full ? oldest_slot_reg : frames_held_reg[nfwa_pkg::SLOT_W-1:0];
    assign frame_end = ({1'b0, element_index_reg} + 1'b1 == vs_eff);
    assign fic_inc   = frames_in_chunk_reg + 1'b1;
    assign held_inc  = frames_held_reg + 1'b1;
    assign held      = full ? win_eff : held_inc;
    assign divisor   = (zero_pad_reg && (held < win_eff)) ? win_eff : held;
    assign emit      = (fic_inc >= win_eff) || eou_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign new_sum = sum_q
                   - (full ? nfwa_pkg::SUM_W'(hist_q) : nfwa_pkg::SUM_W'(0))
                   + nfwa_pkg::SUM_W'(sample_reg);

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_clear = cfg_write && ((cfg_index == nfwa_pkg::CFG_VECTOR_SIZE) ||
                                     (cfg_index == nfwa_pkg::CFG_WINDOW_FRAMES));
    assign eou_clear = finish && frame_end && eou_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nfwa_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = nfwa_pkg::ST_READ;
                end
            end
            nfwa_pkg::ST_READ:
            begin
                state_next = emit ? nfwa_pkg::ST_DIV : nfwa_pkg::ST_IDLE;
            end
            nfwa_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = nfwa_pkg::ST_OUT;
                end
            end
            nfwa_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = nfwa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nfwa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready            = 1'b0;
        store_req.rd_en     = 1'b0;
        store_req.wr_en     = 1'b0;
        store_req.hist_addr = {slot, element_index_reg};
        store_req.dim       = element_index_reg;
        store_req.wr_sample = sample_reg;
        store_req.wr_sum    = new_sum;
        div_req.start       = 1'b0;
        div_req.dividend    = new_sum;
        div_req.divisor     = divisor;
        finish              = 1'b0;
        out_load            = 1'b0;
        case (state_reg)
            nfwa_pkg::ST_IDLE:
            begin
                s_tready        = 1'b1;
                store_req.rd_en = s_tvalid;
            end
            nfwa_pkg::ST_READ:
            begin
                store_req.wr_en = 1'b1;
                div_req.start   = emit;
                finish          = !emit;
            end
            nfwa_pkg::ST_DIV:
            begin
                finish = 1'b0;
            end
            nfwa_pkg::ST_OUT:
            begin
                out_load = out_free;
                finish   = out_free;
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
        store_req.clear = cfg_clear || (finish && frame_end && eou_reg);
    end

    nfwa_store u_store
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (store_req),
        .hist_q (hist_q),
        .sum_q  (sum_q)
    );

    nfwa_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            sample_reg <= s_tdata;
            eou_reg    <= s_tuser;
        end
        if (out_load)
        begin
            m_tdata_reg <= div_quotient;
            m_tuser_reg <= element_index_reg;
            m_tlast_reg <= frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= nfwa_pkg::ST_IDLE;
            vs_reg              <= nfwa_pkg::VS_RESET;
            win_reg             <= nfwa_pkg::WIN_RESET;
            zero_pad_reg        <= 1'b0;
            frames_held_reg     <= '0;
            oldest_slot_reg     <= '0;
            element_index_reg   <= '0;
            frames_in_chunk_reg <= '0;
            m_tvalid_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_write && (cfg_index == nfwa_pkg::CFG_VECTOR_SIZE))
            begin
                vs_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == nfwa_pkg::CFG_WINDOW_FRAMES))
            begin
                win_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == nfwa_pkg::CFG_ZERO_PAD))
            begin
                zero_pad_reg <= cfg_data[0];
            end
            if (cfg_clear || eou_clear)
            begin
                frames_held_reg     <= '0;
                oldest_slot_reg     <= '0;
                element_index_reg   <= '0;
                frames_in_chunk_reg <= '0;
            end
            else if (finish)
            begin
                if (frame_end)
                begin
                    if (full)
                    begin
                        if ({1'b0, oldest_slot_reg} + 1'b1 == win_eff)
                        begin
                            oldest_slot_reg <= '0;
                        end
                        else
                        begin
                            oldest_slot_reg <= oldest_slot_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        frames_held_reg <= held_inc;
                    end
                    frames_in_chunk_reg <= (fic_inc >= win_eff) ? '0 : fic_inc;
                    element_index_reg   <= '0;
                end
                else
                begin
                    element_index_reg <= element_index_reg + 1'b1;
                end
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        frames_held_reg <= win_eff)
        else $error("Frame count exceeds the window.");

    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, element_index_reg} < vs_eff)
        else $error("Element index beyond the vector size.");

    assert property (@(posedge clk) disable iff (!rst_n)
        frames_in_chunk_reg < win_eff)
        else $error("Chunk frame count reached the window.");

    assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (state_reg == nfwa_pkg::ST_IDLE))
        else $error("Item finished without returning to idle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == nfwa_pkg::ST_DIV))
        else $error("Divider finished outside the divide phase.");

endmodule

// File: hw/rtl/nfwa_store.sv
// ----------------------------------------------------------------------------
// nfwa_store
// Sample history ring and per-dimension running sums, both as synchronous
// memories with registered reads. Valid bits zero unwritten sums.
// ----------------------------------------------------------------------------
module nfwa_store
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  nfwa_pkg::store_req_t                req,
    output logic signed [nfwa_pkg::SAMPLE_W-1:0] hist_q,
    output logic signed [nfwa_pkg::SUM_W-1:0]    sum_q
);

    logic signed [nfwa_pkg::SAMPLE_W-1:0] hist_mem [0:nfwa_pkg::HIST_DEPTH-1];
    logic signed [nfwa_pkg::SUM_W-1:0]    sum_mem  [0:nfwa_pkg::MAX_DIMS-1];

    logic [nfwa_pkg::MAX_DIMS-1:0]        valid_reg;
    logic                                 sum_valid_reg;
    logic signed [nfwa_pkg::SAMPLE_W-1:0] hist_rd_reg;
    logic signed [nfwa_pkg::SUM_W-1:0]    sum_rd_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            hist_mem[req.hist_addr] <= req.wr_sample;
            sum_mem[req.dim]        <= req.wr_sum;
        end
        if (req.rd_en)
        begin
            hist_rd_reg <= hist_mem[req.hist_addr];
            sum_rd_reg  <= sum_mem[req.dim];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.dim] <= 1'b1;
            end
            if (req.rd_en)
            begin
                sum_valid_reg <= valid_reg[req.dim];
            end
        end
    end

    assign hist_q = hist_rd_reg;
    assign sum_q  = sum_valid_reg ? sum_rd_reg : '0;

endmodule

// File: hw/rtl/nfwa_div.sv
// ----------------------------------------------------------------------------
// nfwa_div
// Serial signed divider: one restoring step per cycle over the magnitude of
// the running sum, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module nfwa_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  nfwa_pkg::div_req_t                  req,
    output logic                                done,
    output logic [nfwa_pkg::SAMPLE_W-1:0]       quotient
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [nfwa_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic                            neg_reg;
    logic [nfwa_pkg::SUM_W-1:0]      quo_reg;
    logic [nfwa_pkg::SUM_W-1:0]      quo_next;
    logic [nfwa_pkg::CNT_W-1:0]      rem_reg;
    logic [nfwa_pkg::CNT_W-1:0]      rem_next;
    logic [nfwa_pkg::CNT_W-1:0]      divisor_reg;
    logic [nfwa_pkg::CNT_W:0]        trial;
    logic [nfwa_pkg::CNT_W:0]        diff;
    logic                            ge;
    logic [nfwa_pkg::SUM_W-1:0]      magnitude;
    logic [nfwa_pkg::SUM_W-1:0]      signed_quo;

    assign magnitude = req.dividend[nfwa_pkg::SUM_W-1] ?
                       nfwa_pkg::SUM_W'(-req.dividend) : nfwa_pkg::SUM_W'(req.dividend);

    assign trial    = {rem_reg, quo_reg[nfwa_pkg::SUM_W-1]};
    assign diff     = trial - {1'b0, divisor_reg};
    assign ge       = (trial >= {1'b0, divisor_reg});
    assign rem_next = ge ? diff[nfwa_pkg::CNT_W-1:0] : trial[nfwa_pkg::CNT_W-1:0];
    assign quo_next = {quo_reg[nfwa_pkg::SUM_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= nfwa_pkg::DIV_CNT_W'(nfwa_pkg::SUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == nfwa_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg     <= magnitude;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
            neg_reg     <= req.dividend[nfwa_pkg::SUM_W-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign signed_quo = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = signed_quo[nfwa_pkg::SAMPLE_W-1:0];
    assign done       = done_reg;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame window averager testbench
// Streams feature elements into the averager and checks every averaged
// element it emits against a cycle-free model of the windowed sums. Both
// stream sides idle at random, and the registers are rewritten between
// phases, out-of-range values and the extremes of window and vector size
// among them.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [nfwa_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int RANDOM_ITEMS   = 110;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int { EOU_WHOLE_FRAME, EOU_FINAL_ELEMENT, EOU_SCATTERED, EOU_NONE } eou_style_t;
    typedef enum int { SAMPLES_MIXED, SAMPLES_MIN, SAMPLES_MAX } sample_mode_t;

    typedef struct {
        logic [nfwa_pkg::SAMPLE_W-1:0] sample;
        logic                          eou;
        logic                          drain_first;
    } element_t;

    typedef struct {
        logic [nfwa_pkg::SAMPLE_W-1:0] average;
        logic [nfwa_pkg::DIM_W-1:0]    dimension;
        logic                          last;
    } average_t;

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [nfwa_pkg::SAMPLE_W-1:0]   s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [nfwa_pkg::SAMPLE_W-1:0]   m_tdata;
    logic [nfwa_pkg::DIM_W-1:0]      m_tuser;
    logic                            m_tlast;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [nfwa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [nfwa_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    element_t elements_to_send[$];
    average_t averages_due[$];

    logic in_xfer     = 1'b0;
    logic out_xfer    = 1'b0;
    logic cfg_xfer    = 1'b0;
    bit   send_gaps   = 1'b1;
    bit   recv_stalls = 1'b1;
    int   send_wait   = 0;
    int   recv_wait   = 0;
    int   queued_count   = 0;
    int   accepted_count = 0;
    int   errors         = 0;
    int   idle_cycles    = 0;

    logic [nfwa_pkg::CFG_DATA_W-1:0]      reg_vsize  = nfwa_pkg::VS_RESET;
    logic [nfwa_pkg::CFG_DATA_W-1:0]      reg_window = nfwa_pkg::WIN_RESET;
    logic                                 reg_zpad   = 1'b0;
    logic signed [nfwa_pkg::SAMPLE_W-1:0] held_samples [0:nfwa_pkg::HIST_DEPTH-1];
    int                                   dim_totals [0:nfwa_pkg::MAX_DIMS-1];
    int                                   held_count   = 0;
    int                                   oldest_frame = 0;
    int                                   element_pos  = 0;
    int                                   chunk_count  = 0;

    n_frame_window_averager dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clamp_count(input logic [nfwa_pkg::CFG_DATA_W-1:0] v,
                                       input int hi);
        if (v == 0)
            return 1;
        if (int'(v) > hi)
            return hi;
        return int'(v);
    endfunction

    task automatic clear_window();
        for (int i = 0; i < nfwa_pkg::MAX_DIMS; i++)
            dim_totals[i] = 0;
        held_count   = 0;
        oldest_frame = 0;
        element_pos  = 0;
        chunk_count  = 0;
    endtask

    task automatic track_element(input logic signed [nfwa_pkg::SAMPLE_W-1:0] smp,
                                 input logic eou);
        int       vs;
        int       win;
        int       d;
        int       slot;
        int       idx;
        int       frames;
        int       divisor;
        int       avg;
        bit       full;
        bit       frame_end;
        average_t due;
        vs        = clamp_count(reg_vsize, nfwa_pkg::MAX_DIMS);
        win       = clamp_count(reg_window, nfwa_pkg::MAX_WINDOW);
        d         = element_pos % vs;
        full      = held_count >= win;
        slot      = (full ? oldest_frame : held_count) % nfwa_pkg::MAX_WINDOW;
        idx       = slot * nfwa_pkg::MAX_DIMS + d;
        frame_end = (d + 1 == vs);
        if (full)
            dim_totals[d] -= held_samples[idx];
        dim_totals[d] += smp;
        held_samples[idx] = smp;
        if (chunk_count + 1 >= win || eou)
        begin
            frames  = full ? win : held_count + 1;
            divisor = (reg_zpad && frames < win) ? win : frames;
            avg     = dim_totals[d] / divisor;
            due     = '{average: nfwa_pkg::SAMPLE_W'(avg),
                        dimension: nfwa_pkg::DIM_W'(d), last: frame_end};
            averages_due.insert(averages_due.size(), due);
        end
        if (frame_end)
        begin
            if (eou)
                clear_window();
            else
            begin
                if (full)
                    oldest_frame = (oldest_frame + 1) % win;
                else
                    held_count++;
                chunk_count = (chunk_count + 1 >= win) ? 0 : chunk_count + 1;
                element_pos = 0;
            end
        end
        else
            element_pos = d + 1;
    endtask

    always @(negedge clk)
    begin
        element_t nxt;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_xfer)
        begin
            if (send_wait > 0)
            begin
                s_tvalid  <= 1'b0;
                send_wait <= send_wait - 1;
            end
            else if (elements_to_send.size() > 0 &&
                     !(elements_to_send[0].drain_first && averages_due.size() > 0))
            begin
                nxt = elements_to_send.pop_front();
                s_tvalid  <= 1'b1;
                s_tdata   <= nxt.sample;
                s_tuser   <= nxt.eou;
                send_wait <= send_gaps ? $urandom_range(0, 3) : 0;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (out_xfer)
            recv_wait = recv_stalls ? $urandom_range(0, 3) : 0;
        if (!rst_n)
            m_tready <= 1'b0;
        else if (recv_wait > 0)
        begin
            m_tready <= 1'b0;
            if (m_tvalid)
                recv_wait = recv_wait - 1;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        average_t want;
        in_xfer  <= rst_n && s_tvalid && s_tready;
        out_xfer <= rst_n && m_tvalid && m_tready;
        cfg_xfer <= rst_n && cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    nfwa_pkg::CFG_VECTOR_SIZE:
                    begin
                        reg_vsize = cfg_data;
                        clear_window();
                    end
                    nfwa_pkg::CFG_WINDOW_FRAMES:
                    begin
                        reg_window = cfg_data;
                        clear_window();
                    end
                    nfwa_pkg::CFG_ZERO_PAD:
                        reg_zpad = cfg_data[0];
                    default:
                        ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                track_element(s_tdata, s_tuser);
                accepted_count++;
            end
            if (m_tvalid && m_tready)
            begin
                if (averages_due.size() == 0)
                begin
                    $error("unexpected transfer: average %0d dimension %0d",
                           $signed(m_tdata), m_tuser);
                    errors++;
                end
                else
                begin
                    want = averages_due.pop_front();
                    if (m_tdata !== want.average)
                    begin
                        $error("average: expected %0d, got %0d",
                               $signed(want.average), $signed(m_tdata));
                        errors++;
                    end
                    if (m_tuser !== want.dimension)
                    begin
                        $error("dimension: expected %0d, got %0d", want.dimension, m_tuser);
                        errors++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !(s_tvalid && s_tready) && !(m_tvalid && m_tready) &&
            !(cfg_valid && cfg_ready))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic push_element(input logic [nfwa_pkg::SAMPLE_W-1:0] smp, input logic flag,
                                input logic drain);
        element_t item;
        item = '{sample: smp, eou: flag, drain_first: drain};
        elements_to_send.insert(elements_to_send.size(), item);
        queued_count++;
    endtask

    task automatic queue_utterance(input int frames, input eou_style_t style,
                                   input sample_mode_t mode);
        int                            vs;
        logic [nfwa_pkg::SAMPLE_W-1:0] smp;
        logic                          flag;
        vs = clamp_count(reg_vsize, nfwa_pkg::MAX_DIMS);
        for (int f = 0; f < frames; f++)
        begin
            for (int e = 0; e < vs; e++)
            begin
                case (mode)
                    SAMPLES_MIN: smp = 16'h8000;
                    SAMPLES_MAX: smp = 16'h7FFF;
                    default:
                    begin
                        case ($urandom_range(0, 7))
                            0:       smp = 16'h7FFF;
                            1:       smp = 16'h8000;
                            2:       smp = 16'($urandom_range(0, 15)) - 16'd8;
                            default: smp = 16'($urandom);
                        endcase
                    end
                endcase
                case (style)
                    EOU_WHOLE_FRAME:   flag = (f == frames - 1);
                    EOU_FINAL_ELEMENT: flag = (f == frames - 1) && (e == vs - 1);
                    EOU_SCATTERED:     flag = ($urandom_range(0, 7) == 0);
                    default:           flag = 1'b0;
                endcase
                push_element(smp, flag, $urandom_range(0, 99) == 0);
            end
        end
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (accepted_count != queued_count || averages_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [nfwa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nfwa_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(negedge clk);
        while (!cfg_xfer);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int win;
        int pick;
        int phase_end;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_utterance(1, EOU_WHOLE_FRAME, SAMPLES_MIXED);
        settle();

        write_reg(nfwa_pkg::CFG_VECTOR_SIZE, 7'd2);
        write_reg(nfwa_pkg::CFG_WINDOW_FRAMES, 7'd3);
        write_reg(nfwa_pkg::CFG_ZERO_PAD, 7'd1);
        push_element(16'h7FFF, 1'b0, 1'b0);
        push_element(16'h8000, 1'b0, 1'b0);
        // Utterance end on the first element only: it emits, the frame goes on.
        push_element(16'h0000, 1'b1, 1'b0);
        push_element(16'hFFFF, 1'b0, 1'b0);
        push_element(16'h7FFF, 1'b0, 1'b1);
        push_element(16'h7FFF, 1'b0, 1'b0);
        push_element(16'h8000, 1'b1, 1'b0);
        push_element(16'h8000, 1'b1, 1'b0);
        push_element(16'd5, 1'b0, 1'b0);
        push_element(16'd7, 1'b0, 1'b0);
        settle();

        // Zero padding changes while a frame is held; the history must survive.
        write_reg(nfwa_pkg::CFG_ZERO_PAD, 7'h7E);
        push_element(16'd1, 1'b0, 1'b0);
        push_element(16'hFFFD, 1'b1, 1'b0);
        settle();

        write_reg(nfwa_pkg::CFG_VECTOR_SIZE, 7'd0);
        write_reg(nfwa_pkg::CFG_WINDOW_FRAMES, 7'd0);
        write_reg(CFG_UNUSED_INDEX, 7'h7F);
        push_element(16'h8000, 1'b0, 1'b0);
        push_element(16'h7FFF, 1'b1, 1'b0);
        push_element(16'h1234, 1'b0, 1'b0);
        settle();

        phase_end = queued_count + RANDOM_ITEMS;
        while (queued_count < phase_end)
        begin
            send_gaps   = $urandom_range(0, 3) != 0;
            recv_stalls = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 3) != 0)
                write_reg(nfwa_pkg::CFG_VECTOR_SIZE, 7'($urandom_range(0, 5)));
            if ($urandom_range(0, 3) != 0)
                write_reg(nfwa_pkg::CFG_WINDOW_FRAMES, 7'($urandom_range(0, 9)));
            if ($urandom_range(0, 1) != 0)
                write_reg(nfwa_pkg::CFG_ZERO_PAD, 7'($urandom));
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_UNUSED_INDEX, 7'($urandom));
            win = clamp_count(reg_window, nfwa_pkg::MAX_WINDOW);
            repeat ($urandom_range(1, 3))
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    queue_utterance($urandom_range(1, 2 * win + 2), EOU_WHOLE_FRAME,
                                    SAMPLES_MIXED);
                else if (pick < 8)
                    queue_utterance($urandom_range(1, 2 * win + 2), EOU_FINAL_ELEMENT,
                                    SAMPLES_MIXED);
                else if (pick < 9)
                    queue_utterance($urandom_range(1, 2 * win + 2), EOU_SCATTERED,
                                    SAMPLES_MIXED);
                else
                    queue_utterance($urandom_range(1, 2 * win + 2), EOU_NONE,
                                    SAMPLES_MIXED);
            end
            settle();
        end

        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        write_reg(nfwa_pkg::CFG_VECTOR_SIZE, 7'h7F);
        write_reg(nfwa_pkg::CFG_WINDOW_FRAMES, 7'h7F);
        write_reg(nfwa_pkg::CFG_ZERO_PAD, 7'd1);
        queue_utterance(1, EOU_FINAL_ELEMENT, SAMPLES_MIXED);
        settle();

        // Full windows of extreme samples drive the running sums to their limits.
        write_reg(nfwa_pkg::CFG_VECTOR_SIZE, 7'd1);
        write_reg(nfwa_pkg::CFG_WINDOW_FRAMES, 7'd64);
        write_reg(nfwa_pkg::CFG_ZERO_PAD, 7'd0);
        queue_utterance(64, EOU_WHOLE_FRAME, SAMPLES_MIN);
        queue_utterance(65, EOU_NONE, SAMPLES_MAX);
        settle();

        if (errors == 0 && averages_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/nfwa_pkg.sv
hw/rtl/nfwa_store.sv
hw/rtl/nfwa_div.sv
hw/rtl/n_frame_window_averager.sv
dv/testbench.sv
